[rtl/pdwl_pkg.sv]
// Package for the packed DAWG word lookup: widths, default sizes, codes and FSM types.
// Used by the channel interfaces, the store module and the top level.
`default_nettype none
package pdwl_pkg;
	localparam int unsigned STORE_BYTES_DEF   = 1048576;
	localparam int unsigned VOCAB_ENTRIES_DEF = 128;
	localparam int unsigned ADDR_W            = 20;
	localparam int unsigned PTR_W             = 32;
	localparam int unsigned CNT_W             = 7;
	localparam logic [ADDR_W-1:0] ROOT_RESET  = 20'd16;

	typedef enum logic [1:0] {
		OP_GRAPH = 2'd0,
		OP_VOCAB = 2'd1,
		OP_CHAR  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		M_START = 2'd0,
		M_NODE  = 2'd1,
		M_EDGE  = 2'd2,
		M_DEAD  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HDR,
		S_LEN,
		S_FIRST,
		S_LASTC,
		S_OFF,
		S_DECIDE,
		S_CODE,
		S_CODE2,
		S_NHDR,
		S_FIN
	} state_t;
endpackage
`default_nettype wire

[rtl/pdwl_if.sv]
// Channel interfaces of the word lookup: input item, result item and root write.
// Depends on pdwl_pkg for field widths.
`default_nettype none
interface pdwl_req_if import pdwl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [ADDR_W-1:0] address;
	logic [7:0]        data;
	logic              last;
	modport source (output valid, operation, address, data, last, input ready);
	modport sink (input valid, operation, address, data, last, output ready);
endinterface

interface pdwl_rsp_if;
	logic valid;
	logic ready;
	logic found;
	modport source (output valid, found, input ready);
	modport sink (input valid, found, output ready);
endinterface

interface pdwl_cfg_if import pdwl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/pdwl_mem.sv]
// Graph byte store and vocabulary table, each one write and a registered read a cycle.
// Depends on pdwl_pkg.
`default_nettype none
module pdwl_mem import pdwl_pkg::*; #(
	parameter int unsigned STORE_BYTES   = STORE_BYTES_DEF,
	parameter int unsigned VOCAB_ENTRIES = VOCAB_ENTRIES_DEF,
	localparam int unsigned SAW = $clog2(STORE_BYTES),
	localparam int unsigned VAW = $clog2(VOCAB_ENTRIES)
) (
	input  wire logic           clk,
	input  wire logic           g_we,
	input  wire logic           g_re,
	input  wire logic [SAW-1:0] g_addr,
	input  wire logic [7:0]     g_wdata,
	output logic      [7:0]     g_rdata,
	input  wire logic           v_we,
	input  wire logic           v_re,
	input  wire logic [VAW-1:0] v_addr,
	input  wire logic [7:0]     v_wdata,
	output logic      [7:0]     v_rdata
);
	logic [7:0] graph_mem [STORE_BYTES];
	logic [7:0] vocab_mem [VOCAB_ENTRIES];

	always_ff @(posedge clk) begin
		if (g_we) begin
			graph_mem[g_addr] <= g_wdata;
		end
		if (g_re) begin
			g_rdata <= graph_mem[g_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vocab_mem[v_addr] <= v_wdata;
		end
		if (v_re) begin
			v_rdata <= vocab_mem[v_addr];
		end
	end
endmodule
`default_nettype wire

[rtl/packed_dawg_word_lookup_top.sv]
// Packed DAWG word lookup: loads fill the stores, word characters walk the graph.
// Depends on pdwl_pkg, pdwl_if and pdwl_mem.
// Steps: a load is written when accepted; a character inside an edge checks one code and,
// on reaching a node, reads its header; at a node edges are scanned in turn; dead: no reads.
// Throughput: one item at a time; a last character waits while the result register is full.
// Reset clears the walk to word start and the root offset to 16; stores are not cleared.
`default_nettype none
module packed_dawg_word_lookup_top import pdwl_pkg::*; #(
	parameter int unsigned STORE_BYTES   = STORE_BYTES_DEF,
	parameter int unsigned VOCAB_ENTRIES = VOCAB_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pdwl_req_if.sink   req,
	pdwl_rsp_if.source rsp,
	pdwl_cfg_if.sink   cfg
);
	localparam int unsigned SAW = $clog2(STORE_BYTES);
	localparam int unsigned VAW = $clog2(VOCAB_ENTRIES);
	localparam logic [PTR_W-1:0] STORE_LIM = PTR_W'(STORE_BYTES);
	localparam logic [CNT_W:0]   VOCAB_LIM = (CNT_W+1)'(VOCAB_ENTRIES);

	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [ADDR_W-1:0] root_q;
	logic [PTR_W-1:0]  node_ptr_q, code_ptr_q, next_off_q, p_q, codes_q, next_q;
	logic [CNT_W-1:0]  codes_left_q, edges_left_q, n_q;
	logic [1:0]        k_q;
	logic [7:0]        ch_q, code_q;
	logic              last_q, final_q, match_q, voc_ok_s1;
	logic              rsp_valid_q, rsp_found_q;

	logic              accept, is_char;
	logic              g_want, g_oob, g_re, v_re, g_we, v_we;
	logic [PTR_W-1:0]  g_ra, wr_full;
	logic [CNT_W-1:0]  v_idx7;
	logic [7:0]        g_rdata, v_rdata;
	logic              voc_hit, fail;
	logic [CNT_W-1:0]  cl_dec;
	logic              fin_fire;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.found = rsp_found_q;
	assign accept    = req.valid && req.ready;
	assign is_char   = (op_t'(req.operation) == OP_CHAR);
	assign wr_full   = PTR_W'(req.address);
	assign g_we      = accept && (op_t'(req.operation) == OP_GRAPH) && (wr_full < STORE_LIM);
	assign v_we      = accept && (op_t'(req.operation) == OP_VOCAB)
		&& ((CNT_W+1)'(req.address) < VOCAB_LIM) && (req.address[ADDR_W-1:CNT_W+1] == '0);
	assign voc_hit   = voc_ok_s1 && (v_rdata == ch_q);
	assign cl_dec    = codes_left_q - CNT_W'(1);
	assign g_oob     = (g_ra >= STORE_LIM);
	assign g_re      = g_want && !g_oob;
	assign fin_fire  = (state_q == S_FIN) && last_q && (!rsp_valid_q || rsp.ready);

	// Memory request selection per state
	always_comb begin
		g_want = 1'b0;
		g_ra   = '0;
		v_re   = 1'b0;
		v_idx7 = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_char && mode_q != M_DEAD) begin
					if (mode_q == M_EDGE) begin
						g_want = (codes_left_q != '0);
						g_ra   = code_ptr_q;
					end else begin
						g_want = 1'b1;
						g_ra   = (mode_q == M_START) ? PTR_W'(root_q) : node_ptr_q;
					end
				end
			end
			S_HDR: begin
				g_want = (g_rdata[6:0] != '0);
				g_ra   = node_ptr_q + PTR_W'(1);
			end
			S_LEN: begin
				g_want = 1'b1;
				g_ra   = p_q + PTR_W'(1);
			end
			S_FIRST: begin
				g_want = 1'b1;
				g_ra   = codes_q + PTR_W'(n_q) - PTR_W'(1);
				v_re   = 1'b1;
				v_idx7 = g_rdata[6:0];
			end
			S_LASTC: begin
				g_want = !g_rdata[7];
				g_ra   = p_q;
			end
			S_OFF: begin
				g_want = (k_q != 2'd3);
				g_ra   = p_q + PTR_W'(k_q) + PTR_W'(1);
			end
			S_DECIDE: begin
				g_want = match_q || (edges_left_q != CNT_W'(1));
				g_ra   = match_q ? codes_q : p_q;
			end
			S_CODE: begin
				v_re   = 1'b1;
				v_idx7 = g_rdata[6:0];
			end
			S_CODE2: begin
				g_want = voc_hit && (cl_dec == '0) && (next_off_q != '0);
				g_ra   = next_off_q;
			end
			S_NHDR, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		fail    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_char) begin
					if (mode_q == M_DEAD) begin
						state_d = S_FIN;
					end else if (!g_re) begin
						fail    = 1'b1;
						state_d = S_FIN;
					end else begin
						state_d = (mode_q == M_EDGE) ? S_CODE : S_HDR;
					end
				end
			end
			S_HDR, S_LEN, S_FIRST: begin
				if (!g_re) begin
					fail    = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = (state_q == S_HDR) ? S_LEN :
						(state_q == S_FIRST) ? S_LASTC :
						(g_rdata[6:0] != '0) ? S_FIRST : S_OFF;
				end
			end
			S_LASTC, S_OFF: begin
				if (!g_want) begin
					state_d = S_DECIDE;
				end else if (g_oob) begin
					fail    = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_OFF;
				end
			end
			S_DECIDE: begin
				if (!g_re) begin
					fail    = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = match_q ? S_CODE : S_LEN;
				end
			end
			S_CODE: state_d = S_CODE2;
			S_CODE2: begin
				if (!voc_hit) begin
					fail    = 1'b1;
					state_d = S_FIN;
				end else if (g_want) begin
					state_d = g_oob ? S_FIN : S_NHDR;
					fail    = g_oob;
				end else begin
					state_d = S_FIN;
				end
			end
			S_NHDR: state_d = S_FIN;
			S_FIN: begin
				if (!last_q || !rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_START;
			root_q      <= ROOT_RESET;
			final_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				root_q <= cfg.data;
			end
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (fin_fire) begin
				mode_q  <= M_START;
				final_q <= 1'b0;
			end else if (fail) begin
				mode_q  <= M_DEAD;
				final_q <= 1'b0;
			end else if (state_q == S_IDLE && accept && is_char) begin
				final_q <= 1'b0;
				if (mode_q == M_START) begin
					mode_q <= M_NODE;
				end
			end else if (state_q == S_DECIDE && match_q) begin
				mode_q <= M_EDGE;
			end else if (state_q == S_CODE2 && voc_hit) begin
				final_q <= code_q[7] || ((cl_dec == '0) && (next_off_q == '0));
				if (cl_dec == '0 && next_off_q == '0) begin
					mode_q <= M_DEAD;
				end else if (cl_dec != '0) begin
					mode_q <= M_EDGE;
				end
			end else if (state_q == S_NHDR) begin
				final_q <= final_q || g_rdata[7];
				mode_q  <= M_NODE;
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (v_re) begin
			voc_ok_s1 <= ({1'b0, v_idx7} < VOCAB_LIM);
		end
		if (fin_fire) begin
			rsp_found_q <= final_q;
		end
		unique case (state_q)
			S_IDLE: begin
				ch_q   <= req.data;
				last_q <= req.last;
				if (mode_q == M_START) begin
					node_ptr_q <= PTR_W'(root_q);
				end
			end
			S_HDR: begin
				edges_left_q <= g_rdata[6:0];
				p_q          <= node_ptr_q + PTR_W'(1);
			end
			S_LEN: begin
				n_q     <= g_rdata[6:0];
				codes_q <= p_q + PTR_W'(1);
				p_q     <= p_q + PTR_W'(1) + PTR_W'(g_rdata[6:0]);
				match_q <= 1'b0;
				next_q  <= '0;
				k_q     <= '0;
			end
			S_LASTC: begin
				match_q <= voc_hit;
			end
			S_OFF: begin
				next_q[8*k_q +: 8] <= g_rdata;
				k_q                <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					p_q <= p_q + PTR_W'(4);
				end
			end
			S_DECIDE: begin
				if (match_q) begin
					code_ptr_q   <= codes_q;
					codes_left_q <= n_q;
					next_off_q   <= next_q;
				end else begin
					edges_left_q <= edges_left_q - CNT_W'(1);
				end
			end
			S_CODE: begin
				code_q <= g_rdata;
			end
			S_CODE2: begin
				if (voc_hit) begin
					code_ptr_q   <= code_ptr_q + PTR_W'(1);
					codes_left_q <= cl_dec;
				end
			end
			S_NHDR: begin
				node_ptr_q <= next_off_q;
			end
			S_FIRST, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	pdwl_mem #(
		.STORE_BYTES   (STORE_BYTES),
		.VOCAB_ENTRIES (VOCAB_ENTRIES)
	) u_mem (
		.clk     (clk),
		.g_we    (g_we),
		.g_re    (g_re),
		.g_addr  (g_we ? wr_full[SAW-1:0] : g_ra[SAW-1:0]),
		.g_wdata (req.data),
		.g_rdata (g_rdata),
		.v_we    (v_we),
		.v_re    (v_re),
		.v_addr  (v_we ? req.address[VAW-1:0] : v_idx7[VAW-1:0]),
		.v_wdata (req.data),
		.v_rdata (v_rdata)
	);

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		g_re |-> (g_ra < STORE_LIM))
		else $error("graph read beyond store");
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN && last_q))
		else $error("result without last character");
	a_edge_has_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && mode_q == M_EDGE) |-> (codes_left_q != '0))
		else $error("edge walk with no codes left");
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(g_we && g_re))
		else $error("graph write and read together");
endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench of the packed DAWG word lookup: directed table, then random graphs and words.
// Depends on pdwl_pkg, the pdwl_if channel interfaces and packed_dawg_word_lookup_top.
// Results are checked against a behavioural walk predictor held here or a directed row.
`default_nettype none
module testbench;
	import pdwl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE = 200;
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned QUIET_AFTER = 1250;

	logic clk;
	logic arst_n;

	pdwl_req_if req_ch();
	pdwl_rsp_if rsp_ch();
	pdwl_cfg_if cfg_ch();

	packed_dawg_word_lookup_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	byte unsigned gmem[int unsigned];
	byte unsigned vtab[VOCAB_ENTRIES_DEF];
	int unsigned root_q;
	int unsigned node_at;
	int unsigned code_at;
	int unsigned codes_left;
	int unsigned next_off;
	mode_t walk_q;
	bit fin_char;

	bit found_q[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned rand_items;
	int unsigned words_done;
	int unsigned words_found;
	bit quiet;
	bit hold_req;

	// random graph under test
	int g_nodes;
	int g_ne[8];
	bit g_fin[8];
	int g_len[8][4];
	int g_kind[8][4];
	int g_tgt[8][4];
	int unsigned g_bogus[8][4];
	byte unsigned g_code[8][4][3];
	int unsigned g_addr[8];

	typedef struct {
		op_t op;
		int unsigned addr;
		int unsigned data;
		bit last;
		int found;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{OP_GRAPH, 16, 8'h02, 0, -1},
		'{OP_GRAPH, 17, 8'h02, 0, -1},
		'{OP_GRAPH, 18, 8'h01, 0, -1},
		'{OP_GRAPH, 19, 8'h82, 0, -1},
		'{OP_GRAPH, 20, 8'h01, 0, -1},
		'{OP_GRAPH, 21, 8'h03, 0, -1},
		'{OP_GRAPH, 22, 8'h20, 0, -1},
		'{OP_GRAPH, 23, 8'h00, 0, -1},
		'{OP_GRAPH, 24, 8'h00, 0, -1},
		'{OP_GRAPH, 25, 8'h00, 0, -1},
		'{OP_GRAPH, 32, 8'h80, 0, -1},
		'{OP_CHAR, 0, 2, 0, -1},
		'{OP_CHAR, 0, 4, 1, 1},
		'{OP_CHAR, 0, 6, 1, 1},
		'{OP_CHAR, 0, 2, 1, 0},
		'{OP_CHAR, 20'hFFFFF, 18, 1, 0},
		'{OP_CHAR, 0, 6, 0, -1},
		'{OP_CHAR, 0, 2, 1, 0},
		'{OP_NONE, 20'hFFFFF, 8'hFF, 1, -1},
		'{OP_VOCAB, 20'hFFFFF, 8'hFF, 0, -1},
		'{OP_GRAPH, 20'hFFFFF, 8'h00, 0, -1}
	};

	function automatic bit gread(int unsigned a, output int unsigned v);
		v = 0;
		if (a >= STORE_BYTES_DEF) return 0;
		if (gmem.exists(a)) v = gmem[a];
		return 1;
	endfunction

	function automatic bit vmatch(int unsigned code, int unsigned ch);
		int unsigned i;
		i = code & 8'h7F;
		return (i < VOCAB_ENTRIES_DEF) && (vtab[i] == ch);
	endfunction

	function automatic bit pick_edge(int unsigned ch);
		int unsigned p, hdr, n, first, lastc, nxt, b, codes;
		p = node_at;
		if (!gread(p, hdr)) return 0;
		p++;
		for (int i = 0; i < (hdr & 8'h7F); i++) begin
			first = 0;
			lastc = 0;
			nxt = 0;
			if (!gread(p, n)) return 0;
			n &= 8'h7F;
			codes = p + 1;
			p = codes + n;
			if (n > 0) begin
				if (!gread(codes, first) || !gread(codes + n - 1, lastc)) return 0;
			end
			if (!(n > 0 && (lastc & 8'h80))) begin
				for (int k = 0; k < 4; k++) begin
					if (!gread(p + k, b)) return 0;
					nxt |= b << (8 * k);
				end
				p += 4;
			end
			if (n > 0 && vmatch(first, ch)) begin
				code_at = codes;
				codes_left = n;
				next_off = nxt;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void walk_char(int unsigned ch);
		int unsigned code, hdr;
		bit fin;
		fin_char = 0;
		if (walk_q == M_START) begin
			node_at = root_q;
			walk_q = M_NODE;
		end
		if (walk_q == M_NODE) begin
			if (!pick_edge(ch)) begin
				walk_q = M_DEAD;
				return;
			end
			walk_q = M_EDGE;
		end
		if (walk_q != M_EDGE || codes_left == 0) begin
			walk_q = M_DEAD;
			return;
		end
		if (!gread(code_at, code) || !vmatch(code, ch)) begin
			walk_q = M_DEAD;
			return;
		end
		code_at++;
		codes_left = (codes_left - 1) & 8'h7F;
		fin = (code & 8'h80) != 0;
		if (codes_left == 0) begin
			if (next_off == 0) begin
				fin = 1;
				walk_q = M_DEAD;
			end else begin
				if (!gread(next_off, hdr)) begin
					walk_q = M_DEAD;
					return;
				end
				if (hdr & 8'h80) fin = 1;
				node_at = next_off;
				walk_q = M_NODE;
			end
		end
		fin_char = fin;
	endfunction

	// returns the expected found flag, or -1 where the item gives no result
	function automatic int predict_lookup(op_t op, int unsigned addr, int unsigned data, bit last);
		int f;
		case (op)
			OP_GRAPH: begin
				if (addr < STORE_BYTES_DEF) gmem[addr] = data;
				return -1;
			end
			OP_VOCAB: begin
				if (addr < VOCAB_ENTRIES_DEF) vtab[addr] = data;
				return -1;
			end
			OP_CHAR: begin
				if (walk_q == M_DEAD) fin_char = 0;
				else walk_char(data);
				if (!last) return -1;
				f = fin_char;
				walk_q = M_START;
				fin_char = 0;
				return f;
			end
			default: return -1;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (found_q.size() == 0) begin
				$error("found: expected none, actual %0b", rsp_ch.found);
				errors++;
			end else begin
				bit exp_found;
				exp_found = found_q.pop_front();
				if (rsp_ch.found !== exp_found) begin
					$error("found: expected %0b, actual %0b", exp_found, rsp_ch.found);
					errors++;
				end
				words_done++;
				if (exp_found) words_found++;
			end
		end
	end

	initial begin
		bit held;
		held = 0;
		rsp_ch.ready <= 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1;
				rsp_ch.ready <= 0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			rsp_ch.ready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_item(op_t op, int unsigned addr, int unsigned data, bit last,
			int forced = -1);
		int f;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.operation <= op;
		req_ch.address <= addr[ADDR_W-1:0];
		req_ch.data <= data[7:0];
		req_ch.last <= last;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		f = predict_lookup(op, addr, data, last);
		if (forced >= 0) f = forced;
		if (f >= 0) found_q = {found_q, f[0]};
	endtask

	task automatic set_root(int unsigned v);
		req_ch.valid <= 0;
		while (found_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.data <= v[ADDR_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
		root_q = v & 20'hFFFFF;
	endtask

	task automatic build_graph(int unsigned base);
		int unsigned a, off;
		g_nodes = $urandom_range(2, 8);
		for (int i = 0; i < g_nodes; i++) begin
			g_ne[i] = $urandom_range(i == 0 ? 1 : 0, 3);
			g_fin[i] = $urandom_range(0, 3) == 0;
			for (int e = 0; e < g_ne[i]; e++) begin
				int k;
				g_len[i][e] = $urandom_range(1, 3);
				k = $urandom_range(0, 9);
				g_kind[i][e] = k < 2 ? 0 : k == 2 ? 1 : k == 3 ? 3 : 2;
				g_tgt[i][e] = $urandom_range(0, g_nodes - 1);
				g_bogus[i][e] = $urandom | 32'h0010_0000;
				for (int c = 0; c < g_len[i][e]; c++)
					g_code[i][e][c] = {1'($urandom), 7'($urandom)};
				g_code[i][e][g_len[i][e]-1][7] = g_kind[i][e] == 0;
			end
		end
		a = base;
		for (int i = 0; i < g_nodes; i++) begin
			g_addr[i] = a;
			a++;
			for (int e = 0; e < g_ne[i]; e++)
				a += 1 + g_len[i][e] + (g_kind[i][e] == 0 ? 0 : 4);
		end
		a = base;
		for (int i = 0; i < g_nodes; i++) begin
			send_item(OP_GRAPH, a++, {g_fin[i], 7'(g_ne[i])}, 0);
			for (int e = 0; e < g_ne[i]; e++) begin
				send_item(OP_GRAPH, a++, {1'($urandom), 7'(g_len[i][e])}, 0);
				for (int c = 0; c < g_len[i][e]; c++)
					send_item(OP_GRAPH, a++, g_code[i][e][c], 0);
				if (g_kind[i][e] != 0) begin
					off = g_kind[i][e] == 1 ? 0 :
						g_kind[i][e] == 3 ? g_bogus[i][e] : g_addr[g_tgt[i][e]];
					for (int k = 0; k < 4; k++)
						send_item(OP_GRAPH, a++, (off >> (8 * k)) & 8'hFF, 0);
				end
			end
		end
		rand_items += a - base;
	endtask

	task automatic send_word();
		int unsigned chars[$];
		int len, nd, e, r;
		nd = 0;
		len = $urandom_range(1, 9);
		while (chars.size() < len) begin
			if (nd < 0 || g_ne[nd] == 0) begin
				chars = {chars, $urandom_range(0, 255)};
				continue;
			end
			e = $urandom_range(0, g_ne[nd] - 1);
			for (int c = 0; c < g_len[nd][e]; c++) begin
				if ($urandom_range(0, 19) == 0) chars = {chars, $urandom_range(0, 255)};
				else chars = {chars, 32'(vtab[g_code[nd][e][c] & 8'h7F])};
			end
			nd = g_kind[nd][e] == 2 ? g_tgt[nd][e] : -1;
		end
		while (chars.size() > len) void'(chars.pop_back());
		for (int i = 0; i < chars.size(); i++) begin
			if ($urandom_range(0, 11) == 0) begin
				r = $urandom_range(0, 2);
				if (r == 0) send_item(OP_GRAPH, $urandom_range(20'h80000, 20'hFFFFF),
						$urandom_range(0, 255), 1'($urandom));
				else if (r == 1) send_item(OP_VOCAB, $urandom_range(0, 20'hFFFFF),
						$urandom_range(0, 255), 1'($urandom));
				else send_item(OP_NONE, $urandom_range(0, 20'hFFFFF),
						$urandom_range(0, 255), 1'($urandom));
				rand_items++;
			end
			send_item(OP_CHAR, $urandom_range(0, 20'hFFFFF), chars[i], i == chars.size() - 1);
			rand_items++;
		end
	endtask

	initial begin
		int unsigned phase_items;
		int phase;
		errors = 0;
		cycles = 0;
		rand_items = 0;
		words_done = 0;
		words_found = 0;
		quiet = 0;
		hold_req = 0;
		root_q = ROOT_RESET;
		walk_q = M_START;
		node_at = 0;
		code_at = 0;
		codes_left = 0;
		next_off = 0;
		fin_char = 0;
		arst_n = 0;
		req_ch.valid = 0;
		req_ch.operation = OP_NONE;
		req_ch.address = '0;
		req_ch.data = '0;
		req_ch.last = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < VOCAB_ENTRIES_DEF; i++)
			send_item(OP_VOCAB, i, i == VOCAB_ENTRIES_DEF - 1 ? 255 : 2 * i, 0);
		foreach (directed[i])
			send_item(directed[i].op, directed[i].addr, directed[i].data, directed[i].last,
				directed[i].found);

		set_root(20'hFFFFF);
		send_item(OP_CHAR, 0, 2, 1);

		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			build_graph(phase * 32'h1000 + 32'h100);
			set_root(g_addr[0]);
			phase_items = rand_items;
			while (rand_items - phase_items < 180 && rand_items < RANDOM_ITEMS) begin
				if (rand_items > 200) hold_req = 1;
				if (rand_items > QUIET_AFTER) quiet = 1;
				send_word();
			end
			phase++;
		end
		set_root(ROOT_RESET);
		send_item(OP_CHAR, 0, 6, 1);

		req_ch.valid <= 0;
		while (found_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d graphs and %0d checked words, %0d of them found",
			phase, words_done, words_found);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
rtl/pdwl_pkg.sv
rtl/pdwl_if.sv
rtl/pdwl_mem.sv
rtl/packed_dawg_word_lookup_top.sv
dv/testbench.sv
